/* design/dense_graph_shortest_path_core_assert.svh */
// Assertion macros shared by the shortest path core modules.
`ifndef DENSE_GRAPH_SHORTEST_PATH_CORE_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATH_CORE_ASSERT_SVH
`ifndef SYNTH
`define DGSP_ASSERT_CLK(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("dgsp assertion failed");
`define DGSP_ASSERT(lbl, prop) `DGSP_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define DGSP_ASSERT_CLK(lbl, ck, rn, prop)
`define DGSP_ASSERT(lbl, prop)
`endif
`endif

/* design/dgsp_pkg.sv */
// Shared constants, types and state encoding of the shortest path core.
package dgsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 22;
  localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
  localparam int VCNT_BITS    = $clog2(MAX_VERTICES + 1);
  localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
  localparam int MAT_ABITS    = 2 * VIDX_BITS;
  localparam int DENTRY_BITS  = DIST_BITS + 1;

  localparam logic [DIST_BITS-1:0] DIST_INF = '1;

  // Request operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_PICK,
    ST_MARK,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  typedef struct packed {
    logic                   done;
    logic [DIST_BITS-1:0]   dval;
  } dist_entry_t;

  typedef struct packed {
    logic                   we;
    logic [MAT_ABITS-1:0]   waddr;
    logic [WEIGHT_BITS-1:0] wdata;
    logic [MAT_ABITS-1:0]   raddr;
  } mat_req_t;

  typedef struct packed {
    logic                   we;
    logic [VIDX_BITS-1:0]   waddr;
    dist_entry_t            wdata;
    logic [VIDX_BITS-1:0]   raddr;
  } dist_req_t;

  typedef struct packed {
    logic                   load;
    logic [VIDX_BITS-1:0]   vertex;
    logic                   last;
  } out_ctl_t;

endpackage

/* design/dense_graph_shortest_path_core.sv */
// Top level of the dense graph shortest path core.
// Use:
//   Input channel (in_valid/in_ready): a request with in_operation = load writes
//   in_weight into matrix entry (in_from_vertex, in_to_vertex); zero means no
//   edge. A compute request runs shortest paths from vertex 0 over the first
//   vertex_count vertices and yields one result per vertex, in vertex order.
//   Result channel (out_valid/out_ready): out_vertex, out_distance (all ones when
//   unreachable), out_reachable, and out_last on the final result of a run.
//   cfg_we/cfg_wdata write vertex_count (0 acts as 1, above 16 acts as 16).
// Operation:
//   Each compute round sweeps the distance memory once to pick the nearest
//   unvisited vertex and, unless none is reachable, once more to relax its
//   row, one entry per cycle through its single read port. Each result is
//   read from the distance memory and then loaded into the output register.
// Reset and stall:
//   After reset a clearing pass zeroes all 256 weight matrix entries with
//   in_ready low. A stalled receiver holds the output register and pauses the
//   readout; the next request is taken while the last result still waits.
`include "dense_graph_shortest_path_core_assert.svh"
module dense_graph_shortest_path_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [3:0]  in_from_vertex,
  input  logic [3:0]  in_to_vertex,
  input  logic [15:0] in_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_vertex,
  output logic [21:0] out_distance,
  output logic        out_reachable,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  logic [4:0]                      vcount_r;
  logic                            out_valid_r;
  logic [3:0]                      out_vertex_r;
  logic [dgsp_pkg::DIST_BITS-1:0]  out_distance_r;
  logic                            out_reachable_r;
  logic                            out_last_r;

  dgsp_pkg::mat_req_t              mreq;
  dgsp_pkg::dist_req_t             dreq;
  dgsp_pkg::out_ctl_t              octl;
  logic [dgsp_pkg::WEIGHT_BITS-1:0] mrd;
  logic [dgsp_pkg::DENTRY_BITS-1:0] drd_raw;
  dgsp_pkg::dist_entry_t           drd;
  logic                            out_free;

  assign drd      = dgsp_pkg::dist_entry_t'(drd_raw);
  assign out_free = !out_valid_r || out_ready;

  // Weight matrix
  dgsp_ram #(
    .WIDTH (dgsp_pkg::WEIGHT_BITS),
    .DEPTH (dgsp_pkg::MAT_DEPTH)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .raddr (mreq.raddr),
    .rdata (mrd)
  );

  // Distance and visited flag per vertex
  dgsp_ram #(
    .WIDTH (dgsp_pkg::DENTRY_BITS),
    .DEPTH (dgsp_pkg::MAX_VERTICES)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dreq.we),
    .waddr (dreq.waddr),
    .wdata (dreq.wdata),
    .raddr (dreq.raddr),
    .rdata (drd_raw)
  );

  dgsp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_from_vertex (in_from_vertex),
    .in_to_vertex   (in_to_vertex),
    .in_weight      (in_weight),
    .cfg_count      (vcount_r),
    .out_free       (out_free),
    .mrd            (mrd),
    .drd            (drd),
    .mreq           (mreq),
    .dreq           (dreq),
    .octl           (octl)
  );

  // Hold the vertex count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 5'd16;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  // Track the output register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (octl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result fields
  always_ff @(posedge clk) begin
    if (octl.load) begin
      out_vertex_r    <= 4'(octl.vertex);
      out_distance_r  <= drd.dval;
      out_reachable_r <= (drd.dval != dgsp_pkg::DIST_INF);
      out_last_r      <= octl.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_vertex    = out_vertex_r;
  assign out_distance  = 22'(out_distance_r);
  assign out_reachable = out_reachable_r;
  assign out_last      = out_last_r;

  `DGSP_ASSERT(a_out_load_free, octl.load |-> !out_valid_r)

endmodule

/* design/dgsp_ram.sv */
// Generic simple dual-port RAM with registered read data.
module dgsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/dgsp_ctrl.sv */
// Sequencer and datapath: matrix clear, loads, min search, relaxation, readout.
`include "dense_graph_shortest_path_core_assert.svh"
module dgsp_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [3:0]                        in_from_vertex,
  input  logic [3:0]                        in_to_vertex,
  input  logic [15:0]                       in_weight,
  input  logic [4:0]                        cfg_count,
  input  logic                              out_free,
  input  logic [dgsp_pkg::WEIGHT_BITS-1:0]  mrd,
  input  dgsp_pkg::dist_entry_t             drd,
  output dgsp_pkg::mat_req_t                mreq,
  output dgsp_pkg::dist_req_t               dreq,
  output dgsp_pkg::out_ctl_t                octl
);

  dgsp_pkg::state_t state_r, state_nxt;

  logic [dgsp_pkg::MAT_ABITS-1:0] clr_r,   clr_nxt;
  logic [dgsp_pkg::VCNT_BITS-1:0] n_r,     n_nxt;
  logic [dgsp_pkg::VCNT_BITS-1:0] idx_r,   idx_nxt;
  logic [dgsp_pkg::VCNT_BITS-1:0] round_r, round_nxt;
  logic                           pv_r,    pv_nxt;
  logic [dgsp_pkg::VIDX_BITS-1:0] pidx_r,  pidx_nxt;
  logic [dgsp_pkg::VIDX_BITS-1:0] u_r,     u_nxt;
  logic [dgsp_pkg::DIST_BITS-1:0] best_r,  best_nxt;
  logic                           found_r, found_nxt;

  logic                           acc_load;
  logic                           acc_comp;
  logic                           ld_ok;
  logic                           idx_live;
  logic                           scan_end;
  logic                           round_last;
  logic                           idx_final;
  logic [dgsp_pkg::VCNT_BITS-1:0] n_clamp;
  logic [dgsp_pkg::DIST_BITS:0]   sum_w;
  logic [dgsp_pkg::DIST_BITS-1:0] sum_sat;
  logic                           rlx_upd;

  // Decode accepted requests and common conditions
  assign in_ready   = (state_r == dgsp_pkg::ST_IDLE);
  assign acc_load   = in_valid && in_ready && (in_operation == dgsp_pkg::OP_LOAD);
  assign acc_comp   = in_valid && in_ready && (in_operation == dgsp_pkg::OP_COMPUTE);
  assign ld_ok      = (int'(in_from_vertex) < dgsp_pkg::MAX_VERTICES) &&
                      (int'(in_to_vertex) < dgsp_pkg::MAX_VERTICES);
  assign idx_live   = (idx_r < n_r);
  assign scan_end   = (idx_r == n_r) && !pv_r;
  assign idx_final  = (idx_r == n_r - dgsp_pkg::VCNT_BITS'(1));
  assign round_last = ({1'b0, round_r} + (dgsp_pkg::VCNT_BITS+1)'(2)) >= {1'b0, n_r};

  // Clamp the vertex count into 1..MAX_VERTICES
  always_comb begin
    if (cfg_count == 5'd0) begin
      n_clamp = dgsp_pkg::VCNT_BITS'(1);
    end else if (int'(cfg_count) > dgsp_pkg::MAX_VERTICES) begin
      n_clamp = dgsp_pkg::VCNT_BITS'(dgsp_pkg::MAX_VERTICES);
    end else begin
      n_clamp = dgsp_pkg::VCNT_BITS'(cfg_count);
    end
  end

  // Relax candidate: saturate the path sum just below infinity
  assign sum_w   = {1'b0, best_r} + (dgsp_pkg::DIST_BITS+1)'(mrd);
  assign sum_sat = (sum_w >= {1'b0, dgsp_pkg::DIST_INF}) ?
                   (dgsp_pkg::DIST_INF - dgsp_pkg::DIST_BITS'(1)) :
                   sum_w[dgsp_pkg::DIST_BITS-1:0];
  assign rlx_upd = pv_r && (mrd != '0) && !drd.done && (sum_sat < drd.dval);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dgsp_pkg::ST_CLEAR: begin
        if (clr_r == '1) state_nxt = dgsp_pkg::ST_IDLE;
      end
      dgsp_pkg::ST_IDLE: begin
        if (acc_comp) state_nxt = dgsp_pkg::ST_INIT;
      end
      dgsp_pkg::ST_INIT: begin
        if (idx_final) begin
          state_nxt = (n_r == dgsp_pkg::VCNT_BITS'(1)) ? dgsp_pkg::ST_OUT_RD : dgsp_pkg::ST_PICK;
        end
      end
      dgsp_pkg::ST_PICK: begin
        if (scan_end) state_nxt = dgsp_pkg::ST_MARK;
      end
      dgsp_pkg::ST_MARK: begin
        if (best_r == dgsp_pkg::DIST_INF) begin
          state_nxt = round_last ? dgsp_pkg::ST_OUT_RD : dgsp_pkg::ST_PICK;
        end else begin
          state_nxt = dgsp_pkg::ST_RELAX;
        end
      end
      dgsp_pkg::ST_RELAX: begin
        if (scan_end) state_nxt = round_last ? dgsp_pkg::ST_OUT_RD : dgsp_pkg::ST_PICK;
      end
      dgsp_pkg::ST_OUT_RD: begin
        if (out_free) state_nxt = dgsp_pkg::ST_OUT_LD;
      end
      dgsp_pkg::ST_OUT_LD: begin
        if (idx_final) state_nxt = dgsp_pkg::ST_IDLE;
        else           state_nxt = dgsp_pkg::ST_OUT_RD;
      end
      default: state_nxt = dgsp_pkg::ST_CLEAR;
    endcase
  end

  // Memory requests, counters and search registers
  always_comb begin
    clr_nxt   = clr_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    round_nxt = round_r;
    pv_nxt    = 1'b0;
    pidx_nxt  = pidx_r;
    u_nxt     = u_r;
    best_nxt  = best_r;
    found_nxt = found_r;

    mreq       = '0;
    mreq.raddr = {u_r, idx_r[dgsp_pkg::VIDX_BITS-1:0]};
    dreq       = '0;
    dreq.raddr = idx_r[dgsp_pkg::VIDX_BITS-1:0];
    octl       = '0;

    unique case (state_r)
      dgsp_pkg::ST_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = clr_r;
        clr_nxt    = clr_r + dgsp_pkg::MAT_ABITS'(1);
      end
      dgsp_pkg::ST_IDLE: begin
        // Store one weight, or latch the vertex count for a new run
        if (acc_load && ld_ok) begin
          mreq.we    = 1'b1;
          mreq.waddr = {dgsp_pkg::VIDX_BITS'(in_from_vertex),
                        dgsp_pkg::VIDX_BITS'(in_to_vertex)};
          mreq.wdata = dgsp_pkg::WEIGHT_BITS'(in_weight);
        end
        if (acc_comp) begin
          n_nxt   = n_clamp;
          idx_nxt = '0;
        end
      end
      dgsp_pkg::ST_INIT: begin
        dreq.we         = 1'b1;
        dreq.waddr      = idx_r[dgsp_pkg::VIDX_BITS-1:0];
        dreq.wdata.done = 1'b0;
        dreq.wdata.dval = (idx_r == '0) ? '0 : dgsp_pkg::DIST_INF;
        idx_nxt         = idx_r + dgsp_pkg::VCNT_BITS'(1);
        if (idx_final) begin
          idx_nxt   = '0;
          round_nxt = '0;
          found_nxt = 1'b0;
        end
      end
      dgsp_pkg::ST_PICK: begin
        // Sweep the distances, keep the first unvisited minimum
        if (idx_live) begin
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[dgsp_pkg::VIDX_BITS-1:0];
          idx_nxt  = idx_r + dgsp_pkg::VCNT_BITS'(1);
        end
        if (pv_r && !drd.done && (!found_r || (drd.dval < best_r))) begin
          best_nxt  = drd.dval;
          u_nxt     = pidx_r;
          found_nxt = 1'b1;
        end
        if (scan_end) idx_nxt = '0;
      end
      dgsp_pkg::ST_MARK: begin
        dreq.we         = 1'b1;
        dreq.waddr      = u_r;
        dreq.wdata.done = 1'b1;
        dreq.wdata.dval = best_r;
        idx_nxt         = '0;
        if (best_r == dgsp_pkg::DIST_INF) begin
          round_nxt = round_r + dgsp_pkg::VCNT_BITS'(1);
          found_nxt = 1'b0;
        end
      end
      dgsp_pkg::ST_RELAX: begin
        // Read row entry and distance, write back an improved distance in the next cycle
        if (idx_live) begin
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[dgsp_pkg::VIDX_BITS-1:0];
          idx_nxt  = idx_r + dgsp_pkg::VCNT_BITS'(1);
        end
        if (rlx_upd) begin
          dreq.we         = 1'b1;
          dreq.waddr      = pidx_r;
          dreq.wdata.done = 1'b0;
          dreq.wdata.dval = sum_sat;
        end
        if (scan_end) begin
          idx_nxt   = '0;
          round_nxt = round_r + dgsp_pkg::VCNT_BITS'(1);
          found_nxt = 1'b0;
        end
      end
      dgsp_pkg::ST_OUT_RD: begin
        dreq.raddr = idx_r[dgsp_pkg::VIDX_BITS-1:0];
      end
      dgsp_pkg::ST_OUT_LD: begin
        octl.load   = 1'b1;
        octl.vertex = idx_r[dgsp_pkg::VIDX_BITS-1:0];
        octl.last   = idx_final;
        idx_nxt     = idx_r + dgsp_pkg::VCNT_BITS'(1);
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dgsp_pkg::ST_CLEAR;
      clr_r   <= '0;
      n_r     <= dgsp_pkg::VCNT_BITS'(dgsp_pkg::MAX_VERTICES);
      idx_r   <= '0;
      round_r <= '0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
      round_r <= round_nxt;
      pv_r    <= pv_nxt;
      found_r <= found_nxt;
    end
  end

  // Search payload registers
  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    u_r    <= u_nxt;
    best_r <= best_nxt;
  end

  `DGSP_ASSERT(a_mat_wr_src, mreq.we |-> (state_r == dgsp_pkg::ST_CLEAR) || acc_load)
  `DGSP_ASSERT(a_mark_found, (state_r == dgsp_pkg::ST_MARK) |-> found_r)
  `DGSP_ASSERT(a_relax_open, (state_r == dgsp_pkg::ST_RELAX) && dreq.we |-> !drd.done && pv_r)

endmodule
